>>> rtl/mlnps_pkg.sv
// Shared types and constants for the last-note-priority key stack.
package mlnps_pkg;

   localparam int KEY_W = 7;

   localparam logic CMD_NOTE_ON  = 1'b0;
   localparam logic CMD_NOTE_OFF = 1'b1;

   typedef enum logic [1:0] {
      ACT_START   = 2'd0,
      ACT_RETRIG  = 2'd1,
      ACT_RELEASE = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef struct packed {
      logic             cmd;
      logic [KEY_W-1:0] key;
      logic [6:0]       strength;
      logic [3:0]       midi_channel;
   } req_type;

   typedef struct packed {
      action_type       action;
      logic [KEY_W-1:0] voice_note;
      logic [6:0]       voice_velocity;
      logic [3:0]       voice_channel;
      logic             glide_from_current;
      logic [4:0]       keys_held;
      logic             stack_overflow;
   } rsp_type;

   typedef struct packed {
      logic             push;
      logic             capture;
      logic             shift;
      logic [KEY_W-1:0] key;
   } cell_ctrl_type;

endpackage

>>> rtl/mlnps_cell.sv
// One stack slot: holds a key, flags a match and shifts down to close a gap.
module mlnps_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  mlnps_pkg::cell_ctrl_type     ctrl,
   input  logic                         slot_sel,
   input  logic                         live,
   input  logic [mlnps_pkg::KEY_W-1:0]  up_entry,
   input  logic                         found_in,
   output logic [mlnps_pkg::KEY_W-1:0]  entry,
   output logic                         found_out
);
   import mlnps_pkg::*;

   logic [KEY_W-1:0] entry_ff;
   logic [KEY_W-1:0] entry_in;
   logic             hit_ff;
   logic             hit_in;

   assign found_out = found_in | hit_ff;
   assign entry     = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      hit_in   = hit_ff;
      if (ctrl.push && slot_sel) begin
         entry_in = ctrl.key;
      end else if (ctrl.shift && found_out) begin
         entry_in = up_entry;
      end
      if (ctrl.capture) begin
         hit_in = live && (entry_ff == ctrl.key);
      end else if (ctrl.shift) begin
         hit_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         hit_ff   <= hit_in;
      end
   end

endmodule

>>> rtl/mono_last_note_priority_stack_top.sv
// Sequence: a note-on goes from acceptance through the execute and output states; a note-off
// goes through the execute, shift and pick states, the cell row's compare, shift and
// top-select steps, then the output state. One transaction is taken at a time; a new one is
// taken while the previous result waits in the output register.
// Reset: synchronous; clears the stack to zero, the key count, the sounding note and voice.
module mono_last_note_priority_stack_top #(
   parameter int STACK_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mlnps_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mlnps_pkg::rsp_type rsp_data
);
   import mlnps_pkg::*;

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SHIFT,
      S_PICK,
      S_OUT
   } state_type;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [KEY_W-1:0] sounding_ff, sounding_in;
   logic             voice_on_ff, voice_on_in;
   rsp_type          pend_ff, pend_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   cell_ctrl_type    ctrl;
   logic [KEY_W-1:0] entry [STACK_DEPTH];
   logic [KEY_W-1:0] up    [STACK_DEPTH];
   logic             found [STACK_DEPTH+1];
   logic             live  [STACK_DEPTH];
   logic             slot  [STACK_DEPTH];
   logic             top_sel [STACK_DEPTH];
   logic [KEY_W-1:0] top_key;
   logic [CNT_W+4:0] keys_ext;

   assign ctrl.push    = (state_ff == S_EXEC) && (req_ff.cmd == CMD_NOTE_ON);
   assign ctrl.capture = (state_ff == S_EXEC) && (req_ff.cmd == CMD_NOTE_OFF);
   assign ctrl.shift   = (state_ff == S_SHIFT);
   assign ctrl.key     = req_ff.key;
   assign found[0]     = 1'b0;

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      assign live[i] = CNT_W'(i) < cnt_ff;
      assign slot[i] = CNT_W'(i) == cnt_ff;
      if (i == STACK_DEPTH - 1) begin : g_last
         assign up[i]      = '0;
         assign top_sel[i] = live[i];
      end else begin : g_mid
         assign up[i]      = entry[i+1];
         assign top_sel[i] = live[i] && !live[i+1];
      end
      mlnps_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .slot_sel  (slot[i]),
         .live      (live[i]),
         .up_entry  (up[i]),
         .found_in  (found[i]),
         .entry     (entry[i]),
         .found_out (found[i+1])
      );
   end

   always_comb begin
      top_key = '0;
      for (int i = 0; i < STACK_DEPTH; i++) begin
         top_key = top_key | (entry[i] & {KEY_W{top_sel[i]}});
      end
   end

   assign keys_ext  = {5'b0, cnt_ff};
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cnt_in       = cnt_ff;
      sounding_in  = sounding_ff;
      voice_on_in  = voice_on_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (req_ff.cmd == CMD_NOTE_ON) begin
               pend_in                    = '0;
               pend_in.action             = ACT_START;
               pend_in.voice_note         = req_ff.key;
               pend_in.voice_velocity     = req_ff.strength;
               pend_in.voice_channel      = req_ff.midi_channel;
               pend_in.glide_from_current = voice_on_ff;
               if (cnt_ff == CNT_W'(STACK_DEPTH)) begin
                  pend_in.stack_overflow = 1'b1;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               sounding_in = req_ff.key;
               voice_on_in = 1'b1;
               state_in    = S_OUT;
            end else begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (found[STACK_DEPTH]) begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
            state_in = S_PICK;
         end
         S_PICK: begin
            pend_in        = '0;
            pend_in.action = ACT_NONE;
            if (voice_on_ff && (sounding_ff == req_ff.key)) begin
               if (cnt_ff != '0) begin
                  pend_in.action             = ACT_RETRIG;
                  pend_in.voice_note         = top_key;
                  pend_in.voice_velocity     = req_ff.strength;
                  pend_in.voice_channel      = req_ff.midi_channel;
                  pend_in.glide_from_current = 1'b1;
                  sounding_in                = top_key;
               end else begin
                  pend_in.action        = ACT_RELEASE;
                  pend_in.voice_note    = req_ff.key;
                  pend_in.voice_channel = req_ff.midi_channel;
                  voice_on_in           = 1'b0;
               end
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in           = pend_ff;
               rsp_in.keys_held = keys_ext[4:0];
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         sounding_ff  <= '0;
         voice_on_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sounding_ff  <= sounding_in;
         voice_on_ff  <= voice_on_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

`ifndef SYNTHESIS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("A second transaction was accepted while one was in progress.");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && req_ff.cmd == CMD_NOTE_ON && cnt_ff != CNT_W'(STACK_DEPTH))
      |=> cnt_ff == $past(cnt_ff) + CNT_W'(1))
      else $error("A stored note-on did not raise the key count.");

   a_release_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.action == ACT_RELEASE) |-> (rsp_data.keys_held == 5'd0))
      else $error("The voice was released while keys were still held.");

   a_overflow_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.stack_overflow) |-> (rsp_data.action == ACT_START))
      else $error("Overflow was flagged on a result other than a note start.");
`endif

endmodule
